>>> design/dqc_pkg.sv
// Shared constants, opcodes, status codes and control types for the deque with peek cursor.
package dqc_pkg;

	localparam int CAPACITY = 16;
	localparam int SLOTS    = 2 * CAPACITY;
	localparam int ADDR_W   = $clog2(SLOTS);
	localparam int IDX_W    = $clog2(SLOTS + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 6;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK       = 3'd4,
		OP_CUR_FWD    = 3'd5,
		OP_CUR_REV    = 3'd6,
		OP_CUR_FRONT  = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

	typedef struct packed {
		logic accept;
		logic load_out;
	} dqc_cmd_t;

endpackage

>>> design/double_ended_queue_with_peek_cursor_top.sv
// Top level of the double-ended queue with peek cursor.
//
// Input channel: in_valid / in_stall carry one transaction with opcode and data_in
// (push front, push rear, pop front, pop rear, peek, cursor frontward, cursor
// rearward, cursor to front). Output channel: out_valid / out_stall carry exactly
// one result transaction per input: data_out, status, is_empty, is_full, count and
// cursor_at_rear, with the flags as they stand after the operation.
//
// Sequencing: an accepted input is registered together with the read of the word
// store, and the controller then loads the result register from that read. A new
// input is taken only once the controller is back in idle, after the result register is loaded.
//
// Reset: arst_n clears all indices to the middle of the store and marks every
// slot unwritten, so unwritten slots read as zero; the block is ready at once.
//
// Stall: while the result register holds a result, the next input is taken only
// if that result is drained in the same cycle; otherwise in_stall rises.
module double_ended_queue_with_peek_cursor_top import dqc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [DATA_W-1:0]  data_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DATA_W-1:0]  data_out,
	output logic [STAT_W-1:0]  status,
	output logic               is_empty,
	output logic               is_full,
	output logic [COUNT_W-1:0] count,
	output logic               cursor_at_rear
);

	dqc_cmd_t cmd;

	dqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dqc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.data_in        (data_in),
		.data_out       (data_out),
		.status         (status),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.count          (count),
		.cursor_at_rear (cursor_at_rear)
	);

endmodule

>>> design/dqc_ctrl.sv
// Controller state machine: input handshake, operation sequencing and result valid.
module dqc_ctrl import dqc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dqc_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !out_stall;
	assign in_stall     = !((state_q == S_IDLE) && out_free);
	assign cmd.accept   = in_valid && !in_stall;
	assign cmd.load_out = (state_q == S_READ);
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/dqc_dp.sv
// Datapath: front, rear and cursor indices, word store and result registers.
module dqc_dp import dqc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dqc_cmd_t           cmd,
	input  logic [OP_W-1:0]    opcode,
	input  logic [DATA_W-1:0]  data_in,
	output logic [DATA_W-1:0]  data_out,
	output logic [STAT_W-1:0]  status,
	output logic               is_empty,
	output logic               is_full,
	output logic [COUNT_W-1:0] count,
	output logic               cursor_at_rear
);

	logic [DATA_W-1:0] mem_q [SLOTS];
	logic [SLOTS-1:0]  valid_q;

	logic [IDX_W-1:0] front_q, rear_q, cursor_q;
	logic [IDX_W-1:0] front_d, rear_d, cursor_d;

	op_t              op;
	status_t          st_d;
	logic             full, empty;
	logic             wr_en, use_rd;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	logic [DATA_W-1:0] rd_data_s1;
	logic              rd_valid_s1;
	logic              use_rd_s1;
	status_t           status_s1;

	logic [DATA_W-1:0]  data_out_q;
	status_t            status_q;
	logic               empty_q, full_q, at_rear_q;
	logic [COUNT_W-1:0] count_q;

	assign op    = op_t'(opcode);
	assign full  = (rear_q == IDX_W'(SLOTS)) || (front_q == '0);
	assign empty = (front_q == rear_q);

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		cursor_d = cursor_q;
		st_d     = ST_OK;
		wr_en    = 1'b0;
		use_rd   = 1'b0;
		wr_addr  = rear_q[ADDR_W-1:0];
		rd_addr  = cursor_q[ADDR_W-1:0];
		unique case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					front_d = front_q - IDX_W'(1);
					wr_en   = 1'b1;
					wr_addr = front_d[ADDR_W-1:0];
				end
			end
			OP_PUSH_REAR: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					rear_d  = rear_q + IDX_W'(1);
					wr_en   = 1'b1;
					wr_addr = rear_q[ADDR_W-1:0];
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_addr = front_q[ADDR_W-1:0];
					use_rd  = 1'b1;
					front_d = front_q + IDX_W'(1);
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rear_d  = rear_q - IDX_W'(1);
					rd_addr = rear_d[ADDR_W-1:0];
					use_rd  = 1'b1;
				end
			end
			OP_PEEK: begin
				use_rd = 1'b1;
			end
			OP_CUR_FWD: begin
				if (cursor_q == '0) begin
					st_d = ST_LIMIT;
				end else begin
					cursor_d = cursor_q - IDX_W'(1);
				end
			end
			OP_CUR_REV: begin
				if (cursor_q >= IDX_W'(SLOTS - 1)) begin
					st_d = ST_LIMIT;
				end else begin
					cursor_d = cursor_q + IDX_W'(1);
				end
			end
			OP_CUR_FRONT: begin
				cursor_d = front_q;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	// word store: no reset, unwritten slots read as zero through valid_q
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			mem_q[wr_addr] <= data_in;
		end
		if (cmd.accept) begin
			rd_data_s1 <= mem_q[rd_addr];
			use_rd_s1  <= use_rd;
			status_s1  <= st_d;
		end
		if (cmd.load_out) begin
			data_out_q <= (use_rd_s1 && rd_valid_s1) ? rd_data_s1 : '0;
			status_q   <= status_s1;
			empty_q    <= (front_q == rear_q);
			full_q     <= (rear_q == IDX_W'(SLOTS)) || (front_q == '0);
			count_q    <= COUNT_W'(rear_q - front_q);
			at_rear_q  <= (cursor_q == rear_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			front_q     <= IDX_W'(CAPACITY);
			rear_q      <= IDX_W'(CAPACITY);
			cursor_q    <= IDX_W'(CAPACITY);
		end else if (cmd.accept) begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_s1 <= valid_q[rd_addr];
			front_q     <= front_d;
			rear_q      <= rear_d;
			cursor_q    <= cursor_d;
		end
	end

	assign data_out       = data_out_q;
	assign status         = status_q;
	assign is_empty       = empty_q;
	assign is_full        = full_q;
	assign count          = count_q;
	assign cursor_at_rear = at_rear_q;

endmodule

>>> design/dqc_checker.sv
// Port-level assertions for the deque top level, attached by bind.
module dqc_checker import dqc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [DATA_W-1:0]  data_out,
	input logic [STAT_W-1:0]  status,
	input logic               is_empty,
	input logic [COUNT_W-1:0] count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(status))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in back-to-back cycles");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= COUNT_W'(SLOTS))
		else $error("count beyond store size");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (count == '0))
		else $error("empty flag disagrees with count");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty && data_out == '0)
		else $error("refused pop with data or non-empty queue");

endmodule

bind double_ended_queue_with_peek_cursor_top dqc_checker u_dqc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data_out  (data_out),
	.status    (status),
	.is_empty  (is_empty),
	.count     (count)
);
